// ===== rtl/core/top_contributor_credit_table_macros.svh =====
// Assertion macros for the contributor credit table.
// Used by the core RTL; expects signals named clock and reset in scope.
`ifndef TOP_CONTRIBUTOR_CREDIT_TABLE_MACROS_SVH
`define TOP_CONTRIBUTOR_CREDIT_TABLE_MACROS_SVH

// same-cycle implication
`define CTCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ctct_pkg.sv =====
// Shared constants and types for the contributor credit table.
// No dependencies; imported by the channel interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package ctct_pkg;

   localparam int SLOTS     = 8;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TOP_RANKS = 3;
   localparam int CMD_W     = 2;
   localparam int KEY_W     = 32;
   localparam int AMOUNT_W  = 24;
   localparam int TOTAL_W   = 31;
   localparam int SUM_W     = TOTAL_W + 1;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [AMOUNT_W-1:0] amount_type;
   typedef logic [TOTAL_W-1:0]  total_type;
   typedef logic [IDX_W-1:0]    idx_type;

   localparam cmd_type CMD_ADD   = 2'd0;
   localparam cmd_type CMD_QUERY = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   localparam total_type TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam idx_type   LAST_IDX  = IDX_W'(SLOTS - 1);

   typedef struct packed {
      key_type   key;
      total_type total;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/ctct_if.sv =====
// Valid/ready channel interfaces for the contributor credit table.
// Depends on ctct_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface ctct_req_if import ctct_pkg::*; ();
   logic       valid;
   logic       ready;
   cmd_type    command;
   key_type    key;
   amount_type amount;

   modport source (output valid, output command, output key, output amount, input ready);
   modport sink   (input valid, input command, input key, input amount, output ready);
endinterface

interface ctct_rsp_if import ctct_pkg::*; ();
   logic    valid;
   logic    ready;
   key_type first_key;
   key_type second_key;
   key_type third_key;

   modport source (output valid, output first_key, output second_key, output third_key,
                   input ready);
   modport sink   (input valid, input first_key, input second_key, input third_key,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/top_contributor_credit_table.sv =====
// Contributor credit table: SLOTS (key, total) pairs held in a single-port synchronous
// memory with a registered read port, plus one valid flop per slot that reset and the
// clear command drop at once. Add and query transactions walk the memory one slot per
// cycle; add writes back one entry at the end of its walk, query loads the result
// register. The next request is accepted only back in idle. Clear, ignored adds and
// command 3 finish in idle without a walk. A pending result does not block new
// requests; a second query waits at its end until the first is taken.
// Depends on ctct_pkg, ctct_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "top_contributor_credit_table_macros.svh"

module top_contributor_credit_table import ctct_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   ctct_req_if.sink    req_ch,
   ctct_rsp_if.source  rsp_ch
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // slot storage
   entry_type            mem [SLOTS];
   logic [SLOTS-1:0]     valid_ff, valid_in;

   // request hold
   logic       is_query_ff, is_query_in;
   key_type    key_ff, key_in;
   amount_type amount_ff, amount_in;

   // read walk
   idx_type    rd_addr_ff, rd_addr_in;
   logic       issue_ff, issue_in;
   logic       rd_vld_ff, rd_vld_in;
   idx_type    rd_idx_ff, rd_idx_in;
   entry_type  rd_data_ff;
   logic       rd_occ_ff;

   // add bookkeeping
   logic       match_ff, match_in;
   idx_type    match_idx_ff, match_idx_in;
   total_type  match_total_ff, match_total_in;
   logic       empty_ff, empty_in;
   idx_type    empty_idx_ff, empty_idx_in;
   idx_type    min_idx_ff, min_idx_in;
   total_type  min_total_ff, min_total_in;

   // query ranking
   key_type    best_key_ff   [TOP_RANKS];
   key_type    best_key_in   [TOP_RANKS];
   total_type  best_total_ff [TOP_RANKS];
   total_type  best_total_in [TOP_RANKS];

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   key_type    rsp_key_ff [TOP_RANKS];
   key_type    rsp_key_in [TOP_RANKS];

   logic       req_fire;
   logic       rsp_load;
   key_type    cur_key;
   total_type  cur_total;
   logic [SUM_W-1:0] sum;
   total_type  wr_total;
   idx_type    wr_idx;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign req_fire         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.first_key  = rsp_key_ff[0];
   assign rsp_ch.second_key = rsp_key_ff[1];
   assign rsp_ch.third_key  = rsp_key_ff[2];

   // empty slots read as key 0, total 0 whatever the array holds
   assign cur_key   = rd_occ_ff ? rd_data_ff.key   : '0;
   assign cur_total = rd_occ_ff ? rd_data_ff.total : '0;

   assign sum      = {1'b0, match_total_ff} + SUM_W'(amount_ff);
   assign wr_total = match_ff ? (sum[SUM_W-1] ? TOTAL_MAX : sum[TOTAL_W-1:0])
                              : TOTAL_W'(amount_ff);
   assign wr_idx   = match_ff ? match_idx_ff : (empty_ff ? empty_idx_ff : min_idx_ff);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      is_query_in    = is_query_ff;
      key_in         = key_ff;
      amount_in      = amount_ff;
      rd_addr_in     = rd_addr_ff;
      issue_in       = 1'b0;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_addr_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      match_total_in = match_total_ff;
      empty_in       = empty_ff;
      empty_idx_in   = empty_idx_ff;
      min_idx_in     = min_idx_ff;
      min_total_in   = min_total_ff;
      best_key_in    = best_key_ff;
      best_total_in  = best_total_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_query_in = (req_ch.command == CMD_QUERY);
               key_in      = req_ch.key;
               amount_in   = req_ch.amount;
               rd_addr_in  = '0;
               match_in    = 1'b0;
               empty_in    = 1'b0;
               for (int r = 0; r < TOP_RANKS; r++) begin
                  best_key_in[r]   = '0;
                  best_total_in[r] = '0;
               end
               unique case (req_ch.command)
                  CMD_ADD: begin
                     if (req_ch.key != '0 && req_ch.amount != '0) begin
                        state_in = ST_SCAN;
                        issue_in = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     state_in = ST_SCAN;
                     issue_in = 1'b1;
                  end
                  CMD_CLEAR: valid_in = '0;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               rd_vld_in  = 1'b1;
               issue_in   = (rd_addr_ff != LAST_IDX);
               rd_addr_in = (rd_addr_ff == LAST_IDX) ? rd_addr_ff : rd_addr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_occ_ff && cur_key == key_ff) begin
                  match_in       = 1'b1;
                  match_idx_in   = rd_idx_ff;
                  match_total_in = cur_total;
               end
               if (!rd_occ_ff && !empty_ff) begin
                  empty_in     = 1'b1;
                  empty_idx_in = rd_idx_ff;
               end
               // strict compare keeps the lowest slot among equal minima
               if (rd_idx_ff == '0 || cur_total < min_total_ff) begin
                  min_idx_in   = rd_idx_ff;
                  min_total_in = cur_total;
               end
               if (rd_occ_ff) begin
                  if (cur_total > best_total_ff[0]) begin
                     best_total_in[2] = best_total_ff[1];
                     best_key_in[2]   = best_key_ff[1];
                     best_total_in[1] = best_total_ff[0];
                     best_key_in[1]   = best_key_ff[0];
                     best_total_in[0] = cur_total;
                     best_key_in[0]   = cur_key;
                  end else if (cur_total > best_total_ff[1]) begin
                     best_total_in[2] = best_total_ff[1];
                     best_key_in[2]   = best_key_ff[1];
                     best_total_in[1] = cur_total;
                     best_key_in[1]   = cur_key;
                  end else if (cur_total > best_total_ff[2]) begin
                     best_total_in[2] = cur_total;
                     best_key_in[2]   = cur_key;
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = is_query_ff ? ST_DONE : ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            valid_in[wr_idx] = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = best_key_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_query_ff    <= is_query_in;
      key_ff         <= key_in;
      amount_ff      <= amount_in;
      rd_addr_ff     <= rd_addr_in;
      rd_idx_ff      <= rd_idx_in;
      match_ff       <= match_in;
      match_idx_ff   <= match_idx_in;
      match_total_ff <= match_total_in;
      empty_ff       <= empty_in;
      empty_idx_ff   <= empty_idx_in;
      min_idx_ff     <= min_idx_in;
      min_total_ff   <= min_total_in;
      best_key_ff    <= best_key_in;
      best_total_ff  <= best_total_in;
      rsp_key_ff     <= rsp_key_in;
   end

   // single-port slot memory; accesses never overlap since one transaction runs at a time
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         mem[wr_idx] <= '{key: key_ff, total: wr_total};
      end else begin
         rd_data_ff <= mem[rd_addr_ff];
      end
      rd_occ_ff  <= valid_ff[rd_addr_ff];
   end

   `CTCT_ASSERT_NEXT(a_write_sets_valid, state_ff == ST_WRITE,
      valid_ff[$past(wr_idx)], "written slot not marked occupied")
   `CTCT_ASSERT_NEXT(a_clear_empties, req_fire && req_ch.command == CMD_CLEAR,
      valid_ff == '0, "clear left occupied slots")
   `CTCT_ASSERT_NOW(a_rank_order, state_ff == ST_SCAN,
      best_total_ff[0] >= best_total_ff[1] && best_total_ff[1] >= best_total_ff[2],
      "ranking lost its order")
   `CTCT_ASSERT_NOW(a_ranks_packed, rsp_valid_ff && rsp_key_ff[1] != '0,
      rsp_key_ff[0] != '0, "second rank filled before first")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the contributor credit table: directed table, then random traffic.
// Typed rows carry top three keys, else the scoreboard predicts them. Needs ctct_pkg, ctct_if.
`timescale 1ns / 1ps

module tb_top;
   import ctct_pkg::*;

   localparam cmd_type CMD_UNUSED   = 2'd3;
   localparam int      POOL_SIZE    = 12;
   localparam int      RANDOM_ITEMS = 520;
   localparam int      SAT_BURST    = 130;
   localparam int      DRAIN_CYCLES = 4 * (SLOTS + 3);
   localparam int      CYCLE_LIMIT  = 400000;
   localparam int      N_DIRECTED   = 24;

   typedef struct packed {
      key_type first_key;
      key_type second_key;
      key_type third_key;
   } top_keys_type;

   typedef struct packed {
      cmd_type      command;
      key_type      key;
      amount_type   amount;
      logic         typed;
      top_keys_type ranks;
   } stim_row_type;

   localparam top_keys_type NO_KEYS = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ctct_req_if req_if ();
   ctct_rsp_if rsp_if ();

   top_contributor_credit_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   // expected rankings travel with the request so the monitor can pick them up at acceptance
   logic         row_typed;
   top_keys_type row_ranks;

   int send_idle_pct;
   int recv_idle_pct;
   int error_count = 0;
   int cycle_count = 0;

   key_type      shadow_key   [SLOTS] = '{default: '0};
   total_type    shadow_total [SLOTS] = '{default: '0};
   top_keys_type expected_top_q [$];
   top_keys_type want;
   key_type      key_pool [POOL_SIZE];

   stim_row_type directed [N_DIRECTED] = '{
      '{CMD_QUERY,  32'd0,          24'd0,       1'b1, NO_KEYS},
      '{CMD_ADD,    32'd0,          24'd5,       1'b0, NO_KEYS},   // null key, ignored
      '{CMD_ADD,    32'd5,          24'd0,       1'b0, NO_KEYS},   // zero amount, ignored
      '{CMD_QUERY,  32'd0,          24'd0,       1'b1, NO_KEYS},
      '{CMD_ADD,    32'hFFFF_FFFF,  24'hFF_FFFF, 1'b0, NO_KEYS},
      '{CMD_ADD,    32'd1,          24'd1,       1'b0, NO_KEYS},
      '{CMD_QUERY,  32'd0,          24'd0,       1'b1, '{32'hFFFF_FFFF, 32'd1, 32'd0}},
      '{CMD_ADD,    32'd2,          24'd1,       1'b0, NO_KEYS},
      // equal totals: lower slot ranks first
      '{CMD_QUERY,  32'd0,          24'd0,       1'b1, '{32'hFFFF_FFFF, 32'd1, 32'd2}},
      '{CMD_UNUSED, 32'd7,          24'd7,       1'b0, NO_KEYS},
      '{CMD_ADD,    32'd3,          24'd10,      1'b0, NO_KEYS},
      '{CMD_ADD,    32'd4,          24'd20,      1'b0, NO_KEYS},
      '{CMD_ADD,    32'd5,          24'd30,      1'b0, NO_KEYS},
      '{CMD_ADD,    32'd6,          24'd40,      1'b0, NO_KEYS},
      '{CMD_ADD,    32'd7,          24'd50,      1'b0, NO_KEYS},
      '{CMD_ADD,    32'd9,          24'd100,     1'b0, NO_KEYS},   // table full, evicts
      '{CMD_QUERY,  32'd0,          24'd0,       1'b0, NO_KEYS},
      '{CMD_ADD,    32'd2,          24'd5,       1'b0, NO_KEYS},
      '{CMD_ADD,    32'hA5A5_A5A5,  24'h80_0000, 1'b0, NO_KEYS},
      '{CMD_QUERY,  32'd0,          24'd0,       1'b0, NO_KEYS},
      '{CMD_CLEAR,  32'd0,          24'd0,       1'b0, NO_KEYS},
      '{CMD_QUERY,  32'd0,          24'd0,       1'b1, NO_KEYS},
      '{CMD_ADD,    32'h5A5A_5A5A,  24'h55_5555, 1'b0, NO_KEYS},
      '{CMD_QUERY,  32'd0,          24'd0,       1'b0, NO_KEYS}
   };

   function automatic void clear_shadow();
      for (int i = 0; i < SLOTS; i++) begin
         shadow_key[i]   = '0;
         shadow_total[i] = '0;
      end
   endfunction

   function automatic void credit_add(key_type key, amount_type amount);
      logic [SUM_W-1:0] sum;
      int empty_at = -1;
      int min_at   = 0;
      int dest;
      if (key == '0 || amount == '0) return;
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_key[i] == key) begin
            sum = SUM_W'(shadow_total[i]) + SUM_W'(amount);
            shadow_total[i] = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            return;
         end
         if (shadow_key[i] == '0 && empty_at < 0) empty_at = i;
         if (shadow_total[i] < shadow_total[min_at]) min_at = i;
      end
      dest = (empty_at >= 0) ? empty_at : min_at;
      shadow_key[dest]   = key;
      shadow_total[dest] = TOTAL_W'(amount);
   endfunction

   function automatic top_keys_type leading_keys();
      key_type   best_key   [TOP_RANKS];
      total_type best_total [TOP_RANKS];
      bit        placed;
      for (int r = 0; r < TOP_RANKS; r++) begin
         best_key[r]   = '0;
         best_total[r] = '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         placed = 1'b0;
         if (shadow_key[i] != '0 && shadow_total[i] != '0) begin
            for (int r = 0; r < TOP_RANKS; r++) begin
               if (!placed && shadow_total[i] > best_total[r]) begin
                  for (int s = TOP_RANKS - 1; s > r; s--) begin
                     best_total[s] = best_total[s-1];
                     best_key[s]   = best_key[s-1];
                  end
                  best_total[r] = shadow_total[i];
                  best_key[r]   = shadow_key[i];
                  placed = 1'b1;
               end
            end
         end
      end
      return '{best_key[0], best_key[1], best_key[2]};
   endfunction

   function automatic void check_key(string name, key_type expected, key_type actual);
      if (expected !== actual) begin
         $error("%s: expected %h, actual %h", name, expected, actual);
         error_count++;
      end
   endfunction

   // scoreboard: predict at request acceptance, compare at result acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            case (req_if.command)
               CMD_ADD:   credit_add(req_if.key, req_if.amount);
               CMD_QUERY: expected_top_q.push_back(row_typed ? row_ranks : leading_keys());
               CMD_CLEAR: clear_shadow();
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_top_q.size() == 0) begin
               $error("result with no query outstanding: %h %h %h",
                      rsp_if.first_key, rsp_if.second_key, rsp_if.third_key);
               error_count++;
            end else begin
               want = expected_top_q.pop_front();
               check_key("first_key", want.first_key, rsp_if.first_key);
               check_key("second_key", want.second_key, rsp_if.second_key);
               check_key("third_key", want.third_key, rsp_if.third_key);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(cmd_type command, key_type key, amount_type amount,
                            logic typed = 1'b0, top_keys_type ranks = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= command;
      req_if.key     <= key;
      req_if.amount  <= amount;
      row_typed      <= typed;
      row_ranks      <= ranks;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_top_q.size() != 0) @(posedge clock);
   endtask

   function automatic key_type pick_key();
      int r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 12) return $urandom;
      return key_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic amount_type pick_amount();
      int r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 9) return 24'hFF_FFFF;
      if (r < 20) return amount_type'($urandom);
      if (r < 50) return amount_type'($urandom_range(1, 8));   // small: ties on eviction
      return amount_type'($urandom_range(1, 4095));
   endfunction

   task automatic run_random(bit saturate);
      int r;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
         if (key_pool[i] == '0) key_pool[i] = 32'd1;
      end
      if (saturate) begin
         // drive one total into its ceiling
         send_item(CMD_CLEAR, '0, '0);
         for (int i = 0; i < SAT_BURST; i++) send_item(CMD_ADD, key_pool[0], 24'hFF_FFFF);
         send_item(CMD_ADD, key_pool[1], 24'hFF_FFFF);
         send_item(CMD_QUERY, '0, '0);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(99);
         if (r < 70)      send_item(CMD_ADD, pick_key(), pick_amount());
         else if (r < 93) send_item(CMD_QUERY, $urandom, amount_type'($urandom));
         else if (r < 96) send_item(CMD_CLEAR, $urandom, amount_type'($urandom));
         else             send_item(CMD_UNUSED, pick_key(), pick_amount());
      end
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.command = CMD_ADD;
      req_if.key     = '0;
      req_if.amount  = '0;
      row_typed      = 1'b0;
      row_ranks      = '0;
      send_idle_pct  = 38;
      recv_idle_pct  = 64;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].command, directed[i].key, directed[i].amount,
                   directed[i].typed, directed[i].ranks);
      run_random(1'b1);

      // hold off until every result is back before swapping the idle mix
      wait_drained();
      send_idle_pct = 64;
      recv_idle_pct = 38;
      run_random(1'b0);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_top_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== top_contributor_credit_table.f =====
+incdir+rtl/core
rtl/core/ctct_pkg.sv
rtl/core/ctct_if.sv
rtl/core/top_contributor_credit_table.sv
verif/tb_top.sv
